### rtl/wv_pkg.sv
package wv_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RES,
        S_RD1,
        S_RD2,
        S_INTERP,
        S_SUM,
        S_DIV,
        S_STEP,
        S_SCALE,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        SEG_ATTACK  = 2'd0,
        SEG_DECAY   = 2'd1,
        SEG_SUSTAIN = 2'd2,
        SEG_RELEASE = 2'd3
    } seg_t;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_ON    = 2'd1;
    localparam logic [1:0] KIND_OFF   = 2'd2;
    localparam logic [1:0] KIND_WRITE = 2'd3;

    localparam logic [2:0] CFG_ATTACK_TICKS  = 3'd0;
    localparam logic [2:0] CFG_ATTACK_LEVEL  = 3'd1;
    localparam logic [2:0] CFG_DECAY_TICKS   = 3'd2;
    localparam logic [2:0] CFG_DECAY_LEVEL   = 3'd3;
    localparam logic [2:0] CFG_SUSTAIN_TICKS = 3'd4;
    localparam logic [2:0] CFG_SUSTAIN_LEVEL = 3'd5;
    localparam logic [2:0] CFG_RELEASE_TICKS = 3'd6;

    localparam int DIV_STEPS = 16;

    typedef struct packed {
        logic accept;
        logic resolve;
        logic rd1;
        logic rd2;
        logic interp;
        logic sum;
        logic div_step;
        logic step;
        logic scale;
        logic out_load;
        logic out_zero;
    } cmd_t;

    typedef struct packed {
        logic voice_on;
        logic out_free;
    } status_t;

endpackage

### rtl/wv_ram.sv
module wv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/wv_ctrl.sv
module wv_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [1:0]       kind,
    input  wv_pkg::status_t  status,
    output wv_pkg::cmd_t     cmd
);

    wv_pkg::state_t state_reg, state_next;
    logic [3:0]     cnt_reg, cnt_next;
    logic           zero_reg, zero_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wv_pkg::S_IDLE;
            cnt_reg   <= '0;
            zero_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            zero_reg  <= zero_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        zero_next  = zero_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            wv_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    if (kind == wv_pkg::KIND_TICK)
                    begin
                        zero_next  = !status.voice_on;
                        state_next = status.voice_on ? wv_pkg::S_RES : wv_pkg::S_OUT;
                    end
                end
            end
            wv_pkg::S_RES:
            begin
                cmd.resolve = 1'b1;
                state_next  = wv_pkg::S_RD1;
            end
            wv_pkg::S_RD1:
            begin
                cmd.rd1    = 1'b1;
                state_next = wv_pkg::S_RD2;
            end
            wv_pkg::S_RD2:
            begin
                cmd.rd2    = 1'b1;
                state_next = wv_pkg::S_INTERP;
            end
            wv_pkg::S_INTERP:
            begin
                cmd.interp = 1'b1;
                state_next = wv_pkg::S_SUM;
            end
            wv_pkg::S_SUM:
            begin
                cmd.sum    = 1'b1;
                cnt_next   = '0;
                state_next = wv_pkg::S_DIV;
            end
            wv_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 4'd1;
                if (cnt_reg == 4'(wv_pkg::DIV_STEPS - 1))
                begin
                    state_next = wv_pkg::S_STEP;
                end
            end
            wv_pkg::S_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = wv_pkg::S_SCALE;
            end
            wv_pkg::S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = wv_pkg::S_OUT;
            end
            wv_pkg::S_OUT:
            begin
                cmd.out_zero = zero_reg;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = wv_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = wv_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### rtl/wv_dp.sv
module wv_dp #(
    parameter int TABLE_DEPTH = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  wv_pkg::cmd_t       cmd,
    output wv_pkg::status_t    status,
    input  logic [1:0]         kind,
    input  logic [23:0]        phase_step,
    input  logic [7:0]         table_index,
    input  logic signed [15:0] table_value,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [15:0]        cfg_wdata,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] sample_out,
    output logic               note_active
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = ((SAMPLE_BITS > 20) ? SAMPLE_BITS : 20) + 2;
    localparam logic signed [SW-1:0] LIM_HI = SW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] LIM_LO = -LIM_HI - SW'(1);

    logic [15:0] atk_ticks_reg, atk_level_reg, dec_ticks_reg, dec_level_reg;
    logic [15:0] sus_ticks_reg, sus_level_reg, rel_ticks_reg;

    logic [23:0]        phase_acc_reg, phase_step_reg;
    logic               voice_on_reg;
    wv_pkg::seg_t       seg_reg;
    logic [15:0]        time_reg;
    logic signed [17:0] vol_reg, base_reg;
    logic [17:0]        err_reg;

    logic               walk_reg, neg_reg;
    logic [15:0]        len_reg, quo_reg, rem_reg;

    logic signed [15:0] t0_reg, t1_reg;
    logic signed [33:0] iprod_reg;
    logic signed [17:0] data_reg;
    logic signed [35:0] sprod_reg;

    logic               out_valid_reg, active_reg;
    logic signed [15:0] sample_reg;

    logic [AW-1:0]      idx0, raddr;
    logic [15:0]        rdata;
    logic               ram_we, ram_re;

    wv_pkg::seg_t       rs_seg;
    logic [15:0]        rs_time, rs_len, rs_start, rs_target;
    logic signed [17:0] rs_vol, rs_base;
    logic [17:0]        rs_err;
    logic               rs_voice, rs_walk;
    logic signed [16:0] rs_diff, rs_mag;

    logic [16:0]        trial;
    logic signed [17:0] st_c;
    logic [15:0]        st_a;
    logic [19:0]        st_d, st_len1, st_len2;
    logic               st_gt1, st_gt2;

    logic signed [16:0] t_diff;
    logic signed [SW-1:0] s_val;
    logic signed [15:0] sat;

    assign idx0   = AW'(phase_acc_reg[23:16]);
    assign raddr  = cmd.rd1 ? idx0 + AW'(1) : idx0;
    assign ram_re = cmd.resolve | cmd.rd1;
    assign ram_we = cmd.accept && (kind == wv_pkg::KIND_WRITE);

    wv_ram #(
        .WIDTH (16),
        .DEPTH (2 ** AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(table_index)),
        .wdata (table_value),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atk_ticks_reg <= '0;
            atk_level_reg <= 16'hffff;
            dec_ticks_reg <= '0;
            dec_level_reg <= 16'hffff;
            sus_ticks_reg <= '0;
            sus_level_reg <= 16'hffff;
            rel_ticks_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                wv_pkg::CFG_ATTACK_TICKS:  atk_ticks_reg <= cfg_wdata;
                wv_pkg::CFG_ATTACK_LEVEL:  atk_level_reg <= cfg_wdata;
                wv_pkg::CFG_DECAY_TICKS:   dec_ticks_reg <= cfg_wdata;
                wv_pkg::CFG_DECAY_LEVEL:   dec_level_reg <= cfg_wdata;
                wv_pkg::CFG_SUSTAIN_TICKS: sus_ticks_reg <= cfg_wdata;
                wv_pkg::CFG_SUSTAIN_LEVEL: sus_level_reg <= cfg_wdata;
                wv_pkg::CFG_RELEASE_TICKS: rel_ticks_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // resolve segment entries that fall through in the same tick
    always_comb
    begin
        rs_seg   = seg_reg;
        rs_time  = time_reg;
        rs_vol   = vol_reg;
        rs_base  = base_reg;
        rs_err   = err_reg;
        rs_voice = voice_on_reg;
        if (rs_seg == wv_pkg::SEG_ATTACK && rs_time >= atk_ticks_reg)
        begin
            rs_seg  = wv_pkg::SEG_DECAY;
            rs_time = '0;
            rs_vol  = $signed({2'b00, atk_level_reg});
            rs_base = $signed({2'b00, atk_level_reg});
            rs_err  = '0;
        end
        if (rs_seg == wv_pkg::SEG_DECAY && rs_time >= dec_ticks_reg)
        begin
            rs_seg  = wv_pkg::SEG_SUSTAIN;
            rs_time = '0;
            rs_vol  = $signed({2'b00, dec_level_reg});
            rs_base = $signed({2'b00, dec_level_reg});
            rs_err  = '0;
        end
        unique case (rs_seg)
            wv_pkg::SEG_ATTACK:
            begin
                rs_len    = atk_ticks_reg;
                rs_start  = '0;
                rs_target = atk_level_reg;
            end
            wv_pkg::SEG_DECAY:
            begin
                rs_len    = dec_ticks_reg;
                rs_start  = atk_level_reg;
                rs_target = dec_level_reg;
            end
            wv_pkg::SEG_SUSTAIN:
            begin
                rs_len    = sus_ticks_reg;
                rs_start  = dec_level_reg;
                rs_target = sus_level_reg;
            end
            default:
            begin
                rs_len    = rel_ticks_reg;
                rs_start  = sus_level_reg;
                rs_target = '0;
            end
        endcase
        rs_walk = rs_time < rs_len;
        if (!rs_walk && rs_seg == wv_pkg::SEG_SUSTAIN)
        begin
            rs_vol = $signed({2'b00, sus_level_reg});
        end
        if (!rs_walk && rs_seg == wv_pkg::SEG_RELEASE)
        begin
            rs_vol   = '0;
            rs_voice = 1'b0;
        end
        rs_diff = $signed({1'b0, rs_target}) - $signed({1'b0, rs_start});
        rs_mag  = rs_diff[16] ? -rs_diff : rs_diff;
    end

    assign trial = {rem_reg, quo_reg[15]};

    // floor quotient and remainder, then one Bresenham step
    always_comb
    begin
        if (neg_reg && rem_reg != '0)
        begin
            st_c = -$signed({2'b00, quo_reg}) - 18'sd1;
            st_a = len_reg - rem_reg;
        end
        else if (neg_reg)
        begin
            st_c = -$signed({2'b00, quo_reg});
            st_a = '0;
        end
        else
        begin
            st_c = $signed({2'b00, quo_reg});
            st_a = rem_reg;
        end
        st_d    = {2'b00, err_reg} + {3'b000, st_a, 1'b0};
        st_len1 = {4'b0000, len_reg};
        st_len2 = {3'b000, len_reg, 1'b0};
        st_gt1  = st_d > st_len1;
        st_gt2  = st_d > st_len2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg  <= '0;
            phase_step_reg <= '0;
            voice_on_reg   <= 1'b0;
            seg_reg        <= wv_pkg::SEG_ATTACK;
            time_reg       <= '0;
            vol_reg        <= '0;
            base_reg       <= '0;
            err_reg        <= '0;
        end
        else if (cmd.accept && kind == wv_pkg::KIND_ON)
        begin
            if (!voice_on_reg)
            begin
                phase_acc_reg <= '0;
            end
            phase_step_reg <= phase_step;
            voice_on_reg   <= 1'b1;
            seg_reg        <= wv_pkg::SEG_ATTACK;
            time_reg       <= '0;
            vol_reg        <= '0;
            base_reg       <= '0;
            err_reg        <= '0;
        end
        else if (cmd.accept && kind == wv_pkg::KIND_OFF)
        begin
            seg_reg  <= wv_pkg::SEG_RELEASE;
            time_reg <= '0;
            vol_reg  <= $signed({2'b00, sus_level_reg});
            base_reg <= $signed({2'b00, sus_level_reg});
            err_reg  <= '0;
        end
        else if (cmd.resolve)
        begin
            seg_reg      <= rs_seg;
            time_reg     <= rs_time;
            vol_reg      <= rs_vol;
            base_reg     <= rs_base;
            err_reg      <= rs_err;
            voice_on_reg <= rs_voice;
        end
        else if (cmd.sum)
        begin
            phase_acc_reg <= phase_acc_reg + phase_step_reg;
        end
        else if (cmd.step && walk_reg)
        begin
            vol_reg  <= base_reg + st_c + $signed({17'd0, st_gt1});
            base_reg <= base_reg + st_c + $signed({17'd0, st_gt2});
            err_reg  <= st_gt2 ? 18'(st_d - st_len2) : st_d[17:0];
            time_reg <= time_reg + 16'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.resolve)
        begin
            walk_reg <= rs_walk;
            neg_reg  <= rs_diff[16];
            len_reg  <= rs_len;
            quo_reg  <= rs_mag[15:0];
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            if (trial >= {1'b0, len_reg})
            begin
                rem_reg <= 16'(trial - {1'b0, len_reg});
                quo_reg <= {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[15:0];
                quo_reg <= {quo_reg[14:0], 1'b0};
            end
        end
        if (cmd.rd1)
        begin
            t0_reg <= $signed(rdata);
        end
        if (cmd.rd2)
        begin
            t1_reg <= $signed(rdata);
        end
        if (cmd.interp)
        begin
            iprod_reg <= t_diff * $signed({1'b0, phase_acc_reg[15:0]});
        end
        if (cmd.sum)
        begin
            data_reg <= 18'(iprod_reg >>> 16) + 18'(t0_reg);
        end
        if (cmd.scale)
        begin
            sprod_reg <= data_reg * vol_reg;
        end
    end

    assign t_diff = 17'(t1_reg) - 17'(t0_reg);
    assign s_val  = SW'(sprod_reg >>> 16);

    always_comb
    begin
        if (s_val > LIM_HI)
        begin
            sat = LIM_HI[15:0];
        end
        else if (s_val < LIM_LO)
        begin
            sat = LIM_LO[15:0];
        end
        else
        begin
            sat = s_val[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            sample_reg <= cmd.out_zero ? 16'sd0 : sat;
            active_reg <= voice_on_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign sample_out      = sample_reg;
    assign note_active     = active_reg;
    assign status.voice_on = voice_on_reg;
    assign status.out_free = !out_valid_reg || out_ready;

endmodule

### rtl/wavetable_voice_with_adsr_top.sv
// Channel  Dir  tdata                                   tuser
// s_axis   in   [23:0] phase_step [31:24] table_index   [1:0] kind
//               [47:32] table_value
// m_axis   out  [15:0] sample_out                       [0] note_active
// cfg      in   cfg_we, cfg_addr (register index), cfg_wdata
//
// Key on, key off and table write are taken in the idle state and leave it ready for the next transfer.
// A tick while silent goes straight to the output state and loads a zero result there.
// A sounding tick steps through resolve, two table reads, interpolation, the sum,
// the 16-step bit-serial slope divider, the envelope step and scaling before its
// result loads. Input is refused while a tick is at work.
// A result waits in the output register while m_tready is low.
// Reset is asynchronous; the wave table holds no reset value.
module wavetable_voice_with_adsr_top #(
    parameter int TABLE_DEPTH = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // phase_step, table_index, table_value
    input  logic [1:0]  s_tuser,  // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // sample_out
    output logic [0:0]  m_tuser,  // note_active
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    wv_pkg::cmd_t       cmd;
    wv_pkg::status_t    status;
    logic signed [15:0] sample_out;
    logic               note_active;

    wv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    wv_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .kind        (s_tuser),
        .phase_step  (s_tdata[23:0]),
        .table_index (s_tdata[31:24]),
        .table_value ($signed(s_tdata[47:32])),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .sample_out  (sample_out),
        .note_active (note_active)
    );

    assign m_tdata    = sample_out;
    assign m_tuser[0] = note_active;

endmodule

### rtl/wv_chk.sv
module wv_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == 16'd0)
        else $error("nonzero sample without a sounding note");

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == wv_pkg::KIND_TICK |=> !s_tready)
        else $error("input taken while a tick is at work");

endmodule

bind wavetable_voice_with_adsr_top wv_chk u_chk (.*);

### tb/wv_checker.sv
`timescale 1ns / 100ps

module wv_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [0:0]  m_tuser,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    output int          fail_count,
    output int          samples_owed
);

    typedef struct packed {
        logic [15:0] sample;
        logic        active;
    } voice_out_t;

    voice_out_t sample_q[$];

    logic [15:0] atk_ticks, atk_lvl, dec_ticks, dec_lvl, sus_ticks, sus_lvl, rel_ticks;

    logic signed [15:0] wave[256];
    logic [23:0]        phase;
    logic [23:0]        phase_inc;
    logic               sounding;
    wv_pkg::seg_t       seg;
    int                 env_time;
    logic signed [17:0] env_vol;
    logic signed [17:0] env_base;
    logic [17:0]        env_err;

    task automatic seg_walk(input longint from_lvl, input longint to_lvl, input longint span);
        longint diff, q, r, d;
        diff = to_lvl - from_lvl;
        q = diff / span;
        r = diff - q * span;
        if (r < 0)
        begin
            r = r + span;
            q = q - 1;
        end
        d = longint'(env_err) + 2 * r;
        env_vol  = 18'(q + longint'(env_base) + ((d > span) ? 1 : 0));
        env_base = 18'(longint'(env_base) + q + ((d > 2 * span) ? 1 : 0));
        env_err  = 18'((d > 2 * span) ? d - 2 * span : d);
        env_time = env_time + 1;
    endtask

    task automatic enter_seg(input wv_pkg::seg_t next, input longint lvl);
        seg      = next;
        env_time = 0;
        env_vol  = 18'(lvl);
        env_base = 18'(lvl);
        env_err  = '0;
    endtask

    task automatic advance_envelope(output longint lvl);
        if (!sounding)
        begin
            lvl = 0;
            return;
        end
        if (seg == wv_pkg::SEG_ATTACK)
        begin
            if (env_time >= atk_ticks)
                enter_seg(wv_pkg::SEG_DECAY, longint'(atk_lvl));
            else
                seg_walk(0, longint'(atk_lvl), longint'(atk_ticks));
        end
        if (seg == wv_pkg::SEG_DECAY)
        begin
            if (env_time >= dec_ticks)
                enter_seg(wv_pkg::SEG_SUSTAIN, longint'(dec_lvl));
            else
                seg_walk(longint'(atk_lvl), longint'(dec_lvl), longint'(dec_ticks));
        end
        if (seg == wv_pkg::SEG_SUSTAIN)
        begin
            if (env_time >= sus_ticks)
                env_vol = 18'(longint'(sus_lvl));
            else
                seg_walk(longint'(dec_lvl), longint'(sus_lvl), longint'(sus_ticks));
        end
        if (seg == wv_pkg::SEG_RELEASE)
        begin
            if (env_time >= rel_ticks)
            begin
                env_vol  = '0;
                sounding = 1'b0;
            end
            else
                seg_walk(longint'(sus_lvl), 0, longint'(rel_ticks));
        end
        lvl = longint'(env_vol);
    endtask

    task automatic advance_oscillator(output longint smp);
        logic [7:0] i0;
        longint t0, t1, frac;
        if (!sounding)
        begin
            smp = 0;
            return;
        end
        i0    = phase[23:16];
        t0    = longint'(wave[i0]);
        t1    = longint'(wave[8'(i0 + 8'd1)]);
        frac  = longint'(phase[15:0]);
        phase = phase + phase_inc;
        smp   = (((t1 - t0) * frac) >>> 16) + t0;
    endtask

    task automatic apply_item(input logic [1:0] kind, input logic [47:0] data);
        longint smp, lvl, s;
        voice_out_t res;
        case (kind)
            wv_pkg::KIND_ON:
            begin
                if (!sounding)
                    phase = '0;
                phase_inc = data[23:0];
                sounding  = 1'b1;
                enter_seg(wv_pkg::SEG_ATTACK, 0);
            end
            wv_pkg::KIND_OFF:
                enter_seg(wv_pkg::SEG_RELEASE, longint'(sus_lvl));
            wv_pkg::KIND_WRITE:
                wave[data[31:24]] = data[47:32];
            default:
            begin
                advance_oscillator(smp);
                advance_envelope(lvl);
                s = (smp * lvl) >>> 16;
                if (s > 32767)
                    s = 32767;
                if (s < -32768)
                    s = -32768;
                res.sample = s[15:0];
                res.active = sounding;
                sample_q.push_back(res);
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        voice_out_t want;
        if (!rst_n)
        begin
            atk_ticks = '0;
            atk_lvl   = 16'hffff;
            dec_ticks = '0;
            dec_lvl   = 16'hffff;
            sus_ticks = '0;
            sus_lvl   = 16'hffff;
            rel_ticks = '0;
            foreach (wave[i])
                wave[i] = '0;
            phase     = '0;
            phase_inc = '0;
            sounding  = 1'b0;
            seg       = wv_pkg::SEG_ATTACK;
            env_time  = 0;
            env_vol   = '0;
            env_base  = '0;
            env_err   = '0;
            sample_q.delete();
            fail_count   = 0;
            samples_owed = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (sample_q.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    $display("%0t: unexpected transfer sample=%h active=%b",
                             $realtime, m_tdata, m_tuser[0]);
                end
                else
                begin
                    want = sample_q.pop_front();
                    if (m_tdata !== want.sample)
                    begin
                        fail_count = fail_count + 1;
                        $display("%0t: sample_out expected %h actual %h",
                                 $realtime, want.sample, m_tdata);
                    end
                    if (m_tuser[0] !== want.active)
                    begin
                        fail_count = fail_count + 1;
                        $display("%0t: note_active expected %b actual %b",
                                 $realtime, want.active, m_tuser[0]);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_addr)
                    wv_pkg::CFG_ATTACK_TICKS:  atk_ticks = cfg_wdata;
                    wv_pkg::CFG_ATTACK_LEVEL:  atk_lvl   = cfg_wdata;
                    wv_pkg::CFG_DECAY_TICKS:   dec_ticks = cfg_wdata;
                    wv_pkg::CFG_DECAY_LEVEL:   dec_lvl   = cfg_wdata;
                    wv_pkg::CFG_SUSTAIN_TICKS: sus_ticks = cfg_wdata;
                    wv_pkg::CFG_SUSTAIN_LEVEL: sus_lvl   = cfg_wdata;
                    wv_pkg::CFG_RELEASE_TICKS: rel_ticks = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                apply_item(s_tuser, s_tdata);
            samples_owed = sample_q.size();
        end
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;  // phase_step, table_index, table_value
    logic [1:0]  s_tuser;  // kind
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;  // sample_out
    logic [0:0]  m_tuser;  // note_active
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [15:0] cfg_wdata;

    int fail_count;
    int samples_owed;
    bit no_gaps;
    bit hold_go;
    int hold_left;
    int stall_left;

    wavetable_voice_with_adsr_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    wv_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .samples_owed (samples_owed)
    );

    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver: random stalls plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_go)
        begin
            hold_go   = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready  = 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready   = 1'b0;
        end
        else
        begin
            stall_left = gap_len();
            m_tready   = (stall_left == 0);
        end
    end

    task automatic send(input logic [1:0] kind, input logic [23:0] step,
                        input logic [7:0] idx, input logic [15:0] val);
        int gap;
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {val, idx, step};
        do
            @(posedge clk);
        while (!s_tready);
        gap = gap_len();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (samples_owed != 0)
            @(posedge clk);
        repeat (30)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [15:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_envelope(input logic [15:0] at, input logic [15:0] al,
                                input logic [15:0] dt, input logic [15:0] dl,
                                input logic [15:0] st, input logic [15:0] sl,
                                input logic [15:0] rt);
        write_reg(wv_pkg::CFG_ATTACK_TICKS, at);
        write_reg(wv_pkg::CFG_ATTACK_LEVEL, al);
        write_reg(wv_pkg::CFG_DECAY_TICKS, dt);
        write_reg(wv_pkg::CFG_DECAY_LEVEL, dl);
        write_reg(wv_pkg::CFG_SUSTAIN_TICKS, st);
        write_reg(wv_pkg::CFG_SUSTAIN_LEVEL, sl);
        write_reg(wv_pkg::CFG_RELEASE_TICKS, rt);
    endtask

    function automatic logic [23:0] rand_step();
        if ($urandom_range(0, 9) == 0)
            return 24'($urandom);
        return 24'($urandom_range(0, 24'h3ffff));
    endfunction

    task automatic random_items(input int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                send(wv_pkg::KIND_TICK, 24'($urandom), 8'($urandom), 16'($urandom));
            else if (r < 78)
                send(wv_pkg::KIND_ON, rand_step(), 8'($urandom), 16'($urandom));
            else if (r < 86)
                send(wv_pkg::KIND_OFF, 24'($urandom), 8'($urandom), 16'($urandom));
            else
                send(wv_pkg::KIND_WRITE, 24'($urandom), 8'($urandom), 16'($urandom));
        end
    endtask

    task automatic random_small_env(input int max_ticks);
        set_envelope(16'($urandom_range(0, max_ticks)), 16'($urandom),
                     16'($urandom_range(0, max_ticks)), 16'($urandom),
                     16'($urandom_range(0, max_ticks)), 16'($urandom),
                     16'($urandom_range(0, max_ticks)));
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = wv_pkg::KIND_TICK;
        m_tready   = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = wv_pkg::CFG_ATTACK_TICKS;
        cfg_wdata  = '0;
        no_gaps    = 1'b0;
        hold_go    = 1'b0;
        hold_left  = 0;
        stall_left = 0;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // load the whole table so no tick reads an unwritten entry
        for (int i = 0; i < 256; i++)
        begin
            if (i == 0)
                send(wv_pkg::KIND_WRITE, '0, 8'(i), 16'h8000);
            else if (i == 1)
                send(wv_pkg::KIND_WRITE, '0, 8'(i), 16'h7fff);
            else if (i == 255)
                send(wv_pkg::KIND_WRITE, '0, 8'(i), 16'h7fff);
            else
                send(wv_pkg::KIND_WRITE, '0, 8'(i), 16'($urandom));
        end
        drain();

        // directed: zero-length segments, wraps, retrigger, silent key off
        set_envelope(16'h0000, 16'hffff, 16'h0000, 16'hffff, 16'h0000, 16'hffff, 16'h0000);
        send(wv_pkg::KIND_TICK, '0, '0, '0);
        send(wv_pkg::KIND_OFF, '0, '0, '0);
        send(wv_pkg::KIND_TICK, '0, '0, '0);
        send(wv_pkg::KIND_ON, 24'hffffff, '0, '0);
        send(wv_pkg::KIND_TICK, '0, '0, '0);
        send(wv_pkg::KIND_TICK, '0, '0, '0);
        send(wv_pkg::KIND_ON, 24'h008000, '0, '0);
        send(wv_pkg::KIND_TICK, '0, '0, '0);
        send(wv_pkg::KIND_TICK, '0, '0, '0);
        send(wv_pkg::KIND_WRITE, '0, 8'hff, 16'h8000);
        send(wv_pkg::KIND_TICK, '0, '0, '0);
        send(wv_pkg::KIND_OFF, '0, '0, '0);
        send(wv_pkg::KIND_TICK, '0, '0, '0);
        send(wv_pkg::KIND_TICK, '0, '0, '0);
        drain();
        set_envelope(16'd3, 16'hffff, 16'd2, 16'h0000, 16'd2, 16'h8000, 16'd3);
        send(wv_pkg::KIND_ON, 24'hff0000, '0, '0);
        repeat (8)
            send(wv_pkg::KIND_TICK, '0, '0, '0);
        send(wv_pkg::KIND_OFF, '0, '0, '0);
        repeat (4)
            send(wv_pkg::KIND_TICK, '0, '0, '0);
        drain();

        set_envelope(16'hffff, 16'h0000, 16'hffff, 16'h0000, 16'hffff, 16'h0000, 16'hffff);
        random_items(150);
        drain();

        no_gaps = 1'b1;
        random_small_env(6);
        random_items(250);
        drain();
        no_gaps = 1'b0;

        random_small_env(12);
        hold_go = 1'b1;
        random_items(300);
        drain();

        random_small_env(3);
        random_items(300);
        drain();

        random_small_env(40);
        random_items(250);
        drain();

        set_envelope(16'd1, 16'hffff, 16'd5, 16'h0001, 16'd7, 16'hfffe, 16'd9);
        random_items(250);
        drain();

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
